@@ sv/hsfb_pkg.sv @@
// Shared constants and the front-to-back command type of the HDLC-style frame builder.
package hsfb_pkg;

  // Framing bytes
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] FLAG_SUB   = 8'h5E;
  localparam logic [7:0] ESC_SUB    = 8'h5D;
  localparam logic [7:0] ADDR_RESET = 8'h03;
  localparam logic [7:0] CTRL_RESET = 8'h40;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 8'd1;

  // Output sequencer phases
  localparam logic [2:0] PH_OPEN_FLAG  = 3'd0;
  localparam logic [2:0] PH_ADDR       = 3'd1;
  localparam logic [2:0] PH_CTRL       = 3'd2;
  localparam logic [2:0] PH_HDR_XOR    = 3'd3;
  localparam logic [2:0] PH_DATA       = 3'd4;
  localparam logic [2:0] PH_SUB        = 3'd5;
  localparam logic [2:0] PH_CHECK      = 3'd6;
  localparam logic [2:0] PH_CLOSE_FLAG = 3'd7;

  // One classified input item
  typedef struct packed {
    logic       hdr;     // open a frame first
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       esc;     // data needs stuffing
    logic       last;    // close the frame after data
    logic [7:0] chk;     // check byte including data
  } cmd_t;

endpackage

@@ sv/hsfb_front.sv @@
// Front end: accepts payload items, tracks frame state and the XOR check byte.
module hsfb_front import hsfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic [7:0] addr_byte,
  input  logic [7:0] ctrl_byte,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_full
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] chk;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Running check restarts with each new frame
  assign chk = (in_frame_r ? check_r : 8'h00) ^ in_data_byte;

  always_comb begin
    push_cmd.hdr  = !in_frame_r;
    push_cmd.addr = addr_byte;
    push_cmd.ctrl = ctrl_byte;
    push_cmd.data = in_data_byte;
    push_cmd.esc  = (in_data_byte == FLAG_BYTE) || (in_data_byte == ESC_BYTE);
    push_cmd.last = in_last_byte;
    push_cmd.chk  = chk;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    check_nxt    = check_r;
    if (push) begin
      in_frame_nxt = !in_last_byte;
      check_nxt    = in_last_byte ? 8'h00 : chk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      check_r    <= 8'h00;
    end else begin
      in_frame_r <= in_frame_nxt;
      check_r    <= check_nxt;
    end
  end

endmodule

@@ sv/hsfb_queue.sv @@
// Small command queue between front end and output sequencer.
module hsfb_queue import hsfb_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == DEPTH_CNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/hsfb_back.sv @@
// Output sequencer: expands each command into header, stuffed data and trailer bytes.
module hsfb_back import hsfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);

  logic       busy_r, busy_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       run_last_r, frame_end_r;

  logic       advance;
  logic       emit;
  logic [2:0] cur;
  logic [2:0] next_ph;
  logic       done;
  logic [7:0] cur_byte;

  assign advance = !valid_r || out_ready;
  assign emit    = advance && !q_empty;
  assign cur     = busy_r ? phase_r : (head.hdr ? PH_OPEN_FLAG : PH_DATA);

  // Byte for the current phase and the phase that follows
  always_comb begin
    cur_byte = FLAG_BYTE;
    next_ph  = cur;
    done     = 1'b0;
    unique case (cur)
      PH_OPEN_FLAG: begin
        cur_byte = FLAG_BYTE;
        next_ph  = PH_ADDR;
      end
      PH_ADDR: begin
        cur_byte = head.addr;
        next_ph  = PH_CTRL;
      end
      PH_CTRL: begin
        cur_byte = head.ctrl;
        next_ph  = PH_HDR_XOR;
      end
      PH_HDR_XOR: begin
        cur_byte = head.addr ^ head.ctrl;
        next_ph  = PH_DATA;
      end
      PH_DATA: begin
        cur_byte = head.esc ? ESC_BYTE : head.data;
        next_ph  = head.esc ? PH_SUB : PH_CHECK;
        done     = !head.esc && !head.last;
      end
      PH_SUB: begin
        cur_byte = (head.data == FLAG_BYTE) ? FLAG_SUB : ESC_SUB;
        next_ph  = PH_CHECK;
        done     = !head.last;
      end
      PH_CHECK: begin
        cur_byte = head.chk;
        next_ph  = PH_CLOSE_FLAG;
      end
      PH_CLOSE_FLAG: begin
        cur_byte = FLAG_BYTE;
        next_ph  = PH_OPEN_FLAG;
        done     = 1'b1;
      end
      default: begin
        cur_byte = FLAG_BYTE;
        next_ph  = PH_OPEN_FLAG;
        done     = 1'b1;
      end
    endcase
  end

  assign pop = emit && done;

  // Sequencer control
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = !q_empty;
    end
    if (emit) begin
      busy_nxt  = !done;
      phase_nxt = next_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_OPEN_FLAG;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r      <= cur_byte;
      run_last_r  <= done;
      frame_end_r <= (cur == PH_CLOSE_FLAG);
    end
  end

  assign out_valid     = valid_r;
  assign out_out_byte  = byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule

@@ sv/hdlc_style_frame_builder.sv @@
// Top level of the HDLC-style frame builder: config registers, front end, queue, sequencer.
// Payload items enter on the in_ channel and leave framed and byte-stuffed on the out_
// channel. The first item of a frame is preceded by flag 0x7E, address, control and their
// XOR; 0x7E and 0x7D payload bytes go out as 0x7D 0x5E and 0x7D 0x5D; the item marked last
// is followed by the raw XOR check byte and a closing flag flagged by out_frame_end, and
// out_run_last marks the final output byte of each item. An item causes 1 to 8 output
// bytes, driven one byte per cycle unless out_ready stalls the sequencer; an item holds
// the output until its last byte is out. The front end takes one item per cycle while the
// QUEUE_DEPTH-entry command queue has room, so input and output stall independently.
// Address and control registers are sampled as each item is taken, and take effect from
// the next frame header; cfg_ready is always high and unknown indexes are ignored.
module hdlc_style_frame_builder import hsfb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_out_byte,
  output logic                 out_run_last,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] addr_r, addr_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic       push, pop, q_full, q_empty;
  cmd_t       push_cmd, head;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    addr_nxt = addr_r;
    ctrl_nxt = ctrl_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADDRESS: addr_nxt = cfg_data;
        REG_CONTROL: ctrl_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
      ctrl_r <= CTRL_RESET;
    end else begin
      addr_r <= addr_nxt;
      ctrl_r <= ctrl_nxt;
    end
  end

  hsfb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .addr_byte    (addr_r),
    .ctrl_byte    (ctrl_r),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  hsfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  hsfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_out_byte  (out_out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule
